FILE: hw/rtl/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types, constants and table helpers for the route distance accumulator.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int CNT_W  = 24;
  localparam int DIST_W = 32;
  localparam int ACC_W  = 48;

  // Width used for angle differences and their reduction to a quarter turn.
  localparam int AW = 36;

  localparam int FIFO_DEPTH = 2;

  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_TURN  = 64'd3600000000;
  localparam logic [63:0] RAD_SCALE  = PI_Q60 / HALF_TURN;
  localparam logic [63:0] GAIN_Q30   = 64'd652032874;
  localparam logic [31:0] TWO_RADIUS = 32'd12742000;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic signed [LAT_W-1:0] prev_lat;
    logic signed [LON_W-1:0] prev_lon;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic                    has_seg;
    logic                    last;
    logic [CNT_W-1:0]        count;
  } rhd_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED,
    ST_MULR,
    ST_RAD,
    ST_ROT,
    ST_LOAD,
    ST_QA,
    ST_QB,
    ST_QC,
    ST_QD,
    ST_QE,
    ST_QF,
    ST_SQRT,
    ST_VINIT,
    ST_VEC,
    ST_MULD,
    ST_ACC,
    ST_DONE
  } rhd_state_e;

  // atan(2^-i) in Q2.62 from its power series, evaluated at elaboration.
  function automatic logic [63:0] atan_q62(input int unsigned i);
    logic [63:0]  v;
    logic [63:0]  term;
    int unsigned  e;
    v = '0;
    if (i == 0) begin
      v = PI_Q60;
    end else begin
      for (int unsigned k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
          if (k[0]) begin
            v = v - term;
          end else begin
            v = v + term;
          end
        end
      end
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/rhd_front.sv
// ----------------------------------------------------------------------------
// rhd_front
// Accepts route points, tracks the previous point and the point count, and
// queues each point together with what the back end needs to process it.
// ----------------------------------------------------------------------------
module rhd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic signed [rhd_pkg::LAT_W-1:0]  latitude_i,
  input  logic signed [rhd_pkg::LON_W-1:0]  longitude_i,
  input  logic                              last_point_i,
  input  logic                              fifo_full_i,
  output logic                              fifo_push_o,
  output rhd_pkg::rhd_entry_t               entry_o
);

  logic signed [rhd_pkg::LAT_W-1:0] prev_lat_q;
  logic signed [rhd_pkg::LON_W-1:0] prev_lon_q;
  logic [rhd_pkg::CNT_W-1:0]        cnt_q;
  logic [rhd_pkg::CNT_W-1:0]        cnt_d;
  logic                             accept;

  assign accept      = push_i && !fifo_full_i;
  assign fifo_push_o = accept;
  assign cnt_d       = (cnt_q == rhd_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    entry_o.prev_lat = prev_lat_q;
    entry_o.prev_lon = prev_lon_q;
    entry_o.lat      = latitude_i;
    entry_o.lon      = longitude_i;
    entry_o.has_seg  = (cnt_q != '0);
    entry_o.last     = last_point_i;
    entry_o.count    = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lat_q <= '0;
      prev_lon_q <= '0;
      cnt_q      <= '0;
    end else if (accept) begin
      // The last point of a route starts a fresh route.
      if (last_point_i) begin
        prev_lat_q <= '0;
        prev_lon_q <= '0;
        cnt_q      <= '0;
      end else begin
        prev_lat_q <= latitude_i;
        prev_lon_q <= longitude_i;
        cnt_q      <= cnt_d;
      end
    end
  end

endmodule

FILE: hw/rtl/rhd_fifo.sv
// ----------------------------------------------------------------------------
// rhd_fifo
// Short queue of classified points between the front end and the back end.
// ----------------------------------------------------------------------------
module rhd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rhd_pkg::rhd_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output rhd_pkg::rhd_entry_t entry_o
);

  localparam int PTR_W = $clog2(rhd_pkg::FIFO_DEPTH);

  rhd_pkg::rhd_entry_t slot_q [rhd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q;
  logic [PTR_W-1:0]    rd_ptr_q;
  logic [PTR_W:0]      fill_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (fill_q == (PTR_W + 1)'(rhd_pkg::FIFO_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/rhd_back.sv
// ----------------------------------------------------------------------------
// rhd_back
// Sequenced haversine engine: angle reduction, four CORDIC rotation lanes,
// shared multiplier, two bit-serial square roots, CORDIC arctangent and the
// saturating distance accumulator with its result register.
// ----------------------------------------------------------------------------
module rhd_back #(
  parameter int CORDIC_ITERATIONS = 24,
  parameter int ANGLE_FRAC_BITS   = 30
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rhd_pkg::rhd_entry_t                entry_i,
  input  logic                               fifo_empty_i,
  output logic                               fifo_pop_o,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic [rhd_pkg::CNT_W-1:0]          num_points_o,
  output logic [rhd_pkg::DIST_W-1:0]         distance_m_o
);

  localparam int N    = CORDIC_ITERATIONS;
  localparam int F    = ANGLE_FRAC_BITS;
  localparam int W    = F + 4;
  localparam int SW   = F + 2;
  localparam int MW   = (SW > 32) ? SW : 32;
  localparam int PW   = 2 * MW;
  localparam int IW   = $clog2(N);
  localparam int SQN  = F + 1;
  localparam int SCW  = $clog2(SQN);
  localparam int RW   = F + 4;
  localparam int RADW = 2 * F + 2;
  localparam int AW   = rhd_pkg::AW;
  localparam int ACCW = rhd_pkg::ACC_W;

  localparam logic signed [AW-1:0] HALF     = AW'(rhd_pkg::HALF_TURN);
  localparam logic signed [AW-1:0] TWO_HALF = AW'(2 * rhd_pkg::HALF_TURN);
  localparam logic signed [AW-1:0] QUARTER  = AW'(rhd_pkg::HALF_TURN / 2);

  localparam logic [63:0]          GAIN64 =
    (rhd_pkg::GAIN_Q30 + ((64'd1 << (30 - F)) >> 1)) >> (30 - F);
  localparam logic signed [W-1:0]  GAIN   = W'(GAIN64);

  localparam logic [F:0]           ONE_U  = {1'b1, {F{1'b0}}};
  localparam logic signed [SW:0]   ONE_S  = $signed({2'b00, ONE_U});

  localparam logic [PW-1:0]        RAD_RND = PW'(64'd1) << (59 - F);
  localparam logic signed [PW-1:0] Q_RND   = $signed(PW'(64'd1) << (F - 1));
  localparam logic [PW-1:0]        SEG_RND = PW'(64'd1) << (F - 17);

  typedef logic signed [W-1:0] atan_tbl_t [N];

  function automatic atan_tbl_t build_atan();
    atan_tbl_t   t;
    logic [63:0] v;
    for (int i = 0; i < N; i++) begin
      v    = rhd_pkg::atan_q62(i);
      v    = v + (64'd1 << (61 - F));
      t[i] = W'(v >> (62 - F));
    end
    return t;
  endfunction

  localparam atan_tbl_t ATAN = build_atan();

  // Control state.
  rhd_pkg::rhd_state_e state_q, state_d;
  logic [1:0]          idx_q;
  logic [IW-1:0]       iter_q;
  logic [SCW-1:0]      sqc_q;
  logic [ACCW-1:0]     acc_q;
  logic                out_valid_q;

  // Datapath registers.
  rhd_pkg::rhd_entry_t     ent_q;
  logic [30:0]             mag_q;
  logic                    sgn_q;
  logic [3:0]              neg_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [W-1:0]     lx_q [4];
  logic signed [W-1:0]     ly_q [4];
  logic signed [W-1:0]     lz_q [4];
  logic signed [SW-1:0]    sc_q [4];
  logic signed [SW-1:0]    m1_q;
  logic signed [SW-1:0]    m2_q;
  logic signed [SW-1:0]    m3_q;
  logic [RADW-1:0]         sq_rad_q  [2];
  logic [RW-1:0]           sq_rem_q  [2];
  logic [F:0]              sq_root_q [2];
  logic [rhd_pkg::CNT_W-1:0]  out_cnt_q;
  logic [rhd_pkg::DIST_W-1:0] out_dist_q;

  // Combinational helpers.
  logic signed [AW-1:0]    ang;
  logic signed [AW-1:0]    red;
  logic                    fold;
  logic                    red_sgn;
  logic signed [AW-1:0]    red_mag;
  logic signed [W-1:0]     lx_n [4];
  logic signed [W-1:0]     ly_n [4];
  logic signed [W-1:0]     lz_n [4];
  logic signed [W-1:0]     xs;
  logic signed [W-1:0]     ys;
  logic                    up;
  logic                    vec;
  logic signed [MW-1:0]    mul_a;
  logic signed [MW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;
  logic signed [PW-1:0]    q_sum;
  logic signed [SW-1:0]    q_rnd;
  logic signed [SW:0]      a_sum;
  logic [F:0]              a_cl;
  logic [PW-1:0]           r_sum;
  logic signed [W-1:0]     r_w;
  logic [PW-1:0]           seg_sum;
  logic [ACCW-1:0]         seg;
  logic [ACCW:0]           acc_sum;
  logic [RW-1:0]           sq_remx  [2];
  logic [RW-1:0]           sq_trial [2];
  logic [RW-1:0]           sq_rem_n [2];
  logic [F:0]              sq_root_n [2];
  logic signed [W-1:0]     z_clamp;
  logic                    load_out;

  assign empty_o       = !out_valid_q;
  assign num_points_o  = out_cnt_q;
  assign distance_m_o  = out_dist_q;

  // Angle for the current lane, then reduction to at most a quarter turn.
  always_comb begin
    unique case (idx_q)
      2'd0:    ang = AW'(ent_q.lat) - AW'(ent_q.prev_lat);
      2'd1:    ang = AW'(ent_q.lon) - AW'(ent_q.prev_lon);
      2'd2:    ang = AW'(ent_q.prev_lat) <<< 1;
      default: ang = AW'(ent_q.lat) <<< 1;
    endcase
    red = ang;
    if (red >= HALF) begin
      red = red - TWO_HALF;
    end else if (red < -HALF) begin
      red = red + TWO_HALF;
    end
    fold = 1'b0;
    if (red > QUARTER) begin
      red  = red - HALF;
      fold = 1'b1;
    end else if (red < -QUARTER) begin
      red  = red + HALF;
      fold = 1'b1;
    end
    red_sgn = red[AW-1];
    red_mag = red_sgn ? -red : red;
  end

  // One CORDIC step on every lane; lane 0 also serves the vectoring pass.
  assign vec = (state_q == rhd_pkg::ST_VEC);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xs = lx_q[k] >>> iter_q;
      ys = ly_q[k] >>> iter_q;
      up = vec ? !(ly_q[k] > 0) : !lz_q[k][W-1];
      if (up) begin
        lx_n[k] = lx_q[k] - ys;
        ly_n[k] = ly_q[k] + xs;
        lz_n[k] = lz_q[k] - ATAN[iter_q];
      end else begin
        lx_n[k] = lx_q[k] + ys;
        ly_n[k] = ly_q[k] - xs;
        lz_n[k] = lz_q[k] + ATAN[iter_q];
      end
    end
  end

  assign z_clamp = lz_q[0][W-1] ? '0 : lz_q[0];

  // Shared multiplier with a register on its output.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      rhd_pkg::ST_MULR: begin
        mul_a = MW'(mag_q);
        mul_b = MW'(rhd_pkg::RAD_SCALE);
      end
      rhd_pkg::ST_QA: begin
        mul_a = MW'(sc_q[0]);
        mul_b = MW'(sc_q[0]);
      end
      rhd_pkg::ST_QB: begin
        mul_a = MW'(sc_q[2]);
        mul_b = MW'(sc_q[3]);
      end
      rhd_pkg::ST_QC: begin
        mul_a = MW'(sc_q[1]);
        mul_b = MW'(sc_q[1]);
      end
      rhd_pkg::ST_QE: begin
        mul_a = MW'(m2_q);
        mul_b = MW'(m3_q);
      end
      rhd_pkg::ST_MULD: begin
        mul_a = MW'(z_clamp);
        mul_b = MW'(rhd_pkg::TWO_RADIUS);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounded fixed-point product, radians conversion and segment scaling.
  assign q_sum   = prod_q + Q_RND;
  assign q_rnd   = SW'(q_sum >>> F);
  assign a_sum   = (SW + 1)'(m1_q) + (SW + 1)'(q_rnd);
  assign a_cl    = a_sum[SW] ? '0 : ((a_sum > ONE_S) ? ONE_U : a_sum[F:0]);
  assign r_sum   = $unsigned(prod_q) + RAD_RND;
  assign r_w     = W'(r_sum >> (60 - F));
  assign seg_sum = $unsigned(prod_q) + SEG_RND;
  assign seg     = ACCW'(seg_sum >> (F - 16));
  assign acc_sum = {1'b0, acc_q} + {1'b0, seg};

  // Restoring square root, one result bit per cycle in each of two units.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sq_remx[k]   = {sq_rem_q[k][RW-3:0], sq_rad_q[k][RADW-1:RADW-2]};
      sq_trial[k]  = RW'({sq_root_q[k], 2'b01});
      sq_rem_n[k]  = (sq_remx[k] >= sq_trial[k]) ? sq_remx[k] - sq_trial[k] : sq_remx[k];
      sq_root_n[k] = {sq_root_q[k][F-1:0], (sq_remx[k] >= sq_trial[k])};
    end
  end

  assign fifo_pop_o = (state_q == rhd_pkg::ST_IDLE) && !fifo_empty_i;
  assign load_out   = (state_q == rhd_pkg::ST_DONE) && ent_q.last && (!out_valid_q || pop_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rhd_pkg::ST_IDLE: begin
        if (!fifo_empty_i) begin
          state_d = entry_i.has_seg ? rhd_pkg::ST_RED : rhd_pkg::ST_DONE;
        end
      end
      rhd_pkg::ST_RED:  state_d = rhd_pkg::ST_MULR;
      rhd_pkg::ST_MULR: state_d = rhd_pkg::ST_RAD;
      rhd_pkg::ST_RAD:  state_d = (idx_q == 2'd3) ? rhd_pkg::ST_ROT : rhd_pkg::ST_RED;
      rhd_pkg::ST_ROT: begin
        if (iter_q == IW'(N - 1)) begin
          state_d = rhd_pkg::ST_LOAD;
        end
      end
      rhd_pkg::ST_LOAD: state_d = rhd_pkg::ST_QA;
      rhd_pkg::ST_QA:   state_d = rhd_pkg::ST_QB;
      rhd_pkg::ST_QB:   state_d = rhd_pkg::ST_QC;
      rhd_pkg::ST_QC:   state_d = rhd_pkg::ST_QD;
      rhd_pkg::ST_QD:   state_d = rhd_pkg::ST_QE;
      rhd_pkg::ST_QE:   state_d = rhd_pkg::ST_QF;
      rhd_pkg::ST_QF:   state_d = rhd_pkg::ST_SQRT;
      rhd_pkg::ST_SQRT: begin
        if (sqc_q == SCW'(SQN - 1)) begin
          state_d = rhd_pkg::ST_VINIT;
        end
      end
      rhd_pkg::ST_VINIT: state_d = rhd_pkg::ST_VEC;
      rhd_pkg::ST_VEC: begin
        if (iter_q == IW'(N - 1)) begin
          state_d = rhd_pkg::ST_MULD;
        end
      end
      rhd_pkg::ST_MULD: state_d = rhd_pkg::ST_ACC;
      rhd_pkg::ST_ACC:  state_d = rhd_pkg::ST_DONE;
      rhd_pkg::ST_DONE: begin
        if (!ent_q.last || load_out) begin
          state_d = rhd_pkg::ST_IDLE;
        end
      end
      default: state_d = rhd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rhd_pkg::ST_IDLE;
      idx_q       <= '0;
      iter_q      <= '0;
      sqc_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        rhd_pkg::ST_IDLE: idx_q <= '0;
        rhd_pkg::ST_RAD: begin
          idx_q  <= idx_q + 1'b1;
          iter_q <= '0;
        end
        rhd_pkg::ST_ROT, rhd_pkg::ST_VEC: iter_q <= iter_q + 1'b1;
        rhd_pkg::ST_QF:    sqc_q  <= '0;
        rhd_pkg::ST_SQRT:  sqc_q  <= sqc_q + 1'b1;
        rhd_pkg::ST_VINIT: iter_q <= '0;
        rhd_pkg::ST_ACC:   acc_q  <= acc_sum[ACCW] ? '1 : acc_sum[ACCW-1:0];
        default: ;
      endcase
      if (load_out) begin
        acc_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (load_out) begin
      out_cnt_q  <= ent_q.count;
      out_dist_q <= acc_q[ACCW-1:16];
    end
    case (state_q)
      rhd_pkg::ST_IDLE: begin
        if (!fifo_empty_i) begin
          ent_q <= entry_i;
        end
      end
      rhd_pkg::ST_RED: begin
        mag_q        <= red_mag[30:0];
        sgn_q        <= red_sgn;
        neg_q[idx_q] <= fold;
      end
      rhd_pkg::ST_RAD: begin
        lx_q[idx_q] <= GAIN;
        ly_q[idx_q] <= '0;
        lz_q[idx_q] <= sgn_q ? -r_w : r_w;
      end
      rhd_pkg::ST_ROT, rhd_pkg::ST_VEC: begin
        for (int k = 0; k < 4; k++) begin
          lx_q[k] <= lx_n[k];
          ly_q[k] <= ly_n[k];
          lz_q[k] <= lz_n[k];
        end
      end
      rhd_pkg::ST_LOAD: begin
        // Sines of the half differences, cosines of the two latitudes.
        sc_q[0] <= SW'(neg_q[0] ? -ly_q[0] : ly_q[0]);
        sc_q[1] <= SW'(neg_q[1] ? -ly_q[1] : ly_q[1]);
        sc_q[2] <= SW'(neg_q[2] ? -lx_q[2] : lx_q[2]);
        sc_q[3] <= SW'(neg_q[3] ? -lx_q[3] : lx_q[3]);
      end
      rhd_pkg::ST_QB: m1_q <= q_rnd;
      rhd_pkg::ST_QC: m2_q <= q_rnd;
      rhd_pkg::ST_QD: m3_q <= q_rnd;
      rhd_pkg::ST_QF: begin
        sq_rad_q[0]  <= RADW'({a_cl, {F{1'b0}}});
        sq_rad_q[1]  <= RADW'({ONE_U - a_cl, {F{1'b0}}});
        sq_rem_q[0]  <= '0;
        sq_rem_q[1]  <= '0;
        sq_root_q[0] <= '0;
        sq_root_q[1] <= '0;
      end
      rhd_pkg::ST_SQRT: begin
        for (int k = 0; k < 2; k++) begin
          sq_rad_q[k]  <= sq_rad_q[k] << 2;
          sq_rem_q[k]  <= sq_rem_n[k];
          sq_root_q[k] <= sq_root_n[k];
        end
      end
      rhd_pkg::ST_VINIT: begin
        lx_q[0] <= W'(sq_root_q[1]);
        ly_q[0] <= W'(sq_root_q[0]);
        lz_q[0] <= '0;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/route_haversine_distance_accumulator.sv
// ----------------------------------------------------------------------------
// route_haversine_distance_accumulator
// Sums haversine great-circle segment lengths over a route of points.
// ----------------------------------------------------------------------------
// Points enter through a two-beat queue and are processed one at a time by a
// sequenced fixed-point engine. The first point of a route has no segment and
// passes straight to the engine's done state; every later point runs the
// CORDIC rotation pass over four lanes, the bit-serial square roots and the
// CORDIC arctangent pass, and the products around them share one multiplier.
// The route total is emitted as one result beat on the point marked last,
// and that point holds the engine while an earlier result beat still waits.
module route_haversine_distance_accumulator #(
  parameter int CORDIC_ITERATIONS = 24,
  parameter int ANGLE_FRAC_BITS   = 30
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [rhd_pkg::LAT_W-1:0]  latitude_i,
  input  logic signed [rhd_pkg::LON_W-1:0]  longitude_i,
  input  logic                              last_point_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [rhd_pkg::CNT_W-1:0]         num_points_o,
  output logic [rhd_pkg::DIST_W-1:0]        distance_m_o
);

  rhd_pkg::rhd_entry_t front_entry;
  rhd_pkg::rhd_entry_t back_entry;
  logic                fifo_push;
  logic                fifo_pop;
  logic                fifo_empty;

  rhd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .latitude_i   (latitude_i),
    .longitude_i  (longitude_i),
    .last_point_i (last_point_i),
    .fifo_full_i  (full),
    .fifo_push_o  (fifo_push),
    .entry_o      (front_entry)
  );

  rhd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .entry_o (back_entry)
  );

  rhd_back #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
    .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (back_entry),
    .fifo_empty_i  (fifo_empty),
    .fifo_pop_o    (fifo_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .num_points_o  (num_points_o),
    .distance_m_o  (distance_m_o)
  );

endmodule
